/* hdl/im2col_pkg.sv */
// Shared types, constants and helper functions for the im2col gather address generator.
// Used by im2col_cfg, im2col_split, im2col_addr and the top level; depends on nothing.
package im2col_pkg;

  localparam int MAX_SIDE     = 256;
  localparam int MAX_CHANNELS = 1024;

  localparam int PIX_W  = 17;
  localparam int COL_W  = 14;
  localparam int ADDR_W = 26;
  localparam int SIDE_W = 9;
  localparam int CH_W   = 11;
  localparam int CFG_W  = 11;
  localparam int IDX_W  = 3;

  localparam int SPLIT_STAGES = PIX_W + 1;
  localparam int ADDR_STAGES  = 5;

  typedef enum logic [IDX_W-1:0] {
    REG_IN_HEIGHT     = 3'd0,
    REG_IN_WIDTH      = 3'd1,
    REG_IN_CHANNELS   = 3'd2,
    REG_KERNEL_IS_3X3 = 3'd3,
    REG_STRIDE_ROWS   = 3'd4,
    REG_STRIDE_COLS   = 3'd5,
    REG_PAD_ROWS      = 3'd6,
    REG_PAD_COLS      = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_FETCH = 2'd0,
    KIND_PAD   = 2'd1,
    KIND_ZERO  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [SIDE_W-1:0] h;
    logic [SIDE_W-1:0] w;
    logic [CH_W-1:0]   c;
    logic              k3;
    logic [2:0]        sr;
    logic [2:0]        sc;
    logic [1:0]        pr;
    logic [1:0]        pc;
    logic [SIDE_W-1:0] oh;
    logic [SIDE_W-1:0] ow;
    logic [PIX_W-1:0]  npix;
    logic [COL_W-1:0]  kk;
    logic [11:0]       c3;
    logic [12:0]       c6;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pix;
    logic [COL_W-1:0]  col;
    logic [PIX_W-1:0]  quo;
    logic [SIDE_W-1:0] rem;
    logic [1:0]        krow;
    logic [1:0]        kcol;
    logic              zcol;
    logic              zero;
  } split_t;

  typedef struct packed {
    kind_t             kind;
    logic              zero;
    logic [11:0]       ihp;
    logic [11:0]       iwp;
    logic [9:0]        ch;
    logic [PIX_W-1:0]  base;
    logic [ADDR_W-1:0] addr;
  } addr_t;

  // Output size along one axis, (side + 2*pad - k) / stride + 1, or zero when empty.
  // The division by the small stride uses reciprocal multiplies that are exact below 263.
  function automatic logic [SIDE_W-1:0] out_size(logic [SIDE_W-1:0] side, logic [1:0] pad,
                                                 logic k3, logic [2:0] stride);
    logic [SIDE_W:0]   span;
    logic [SIDE_W:0]   k;
    logic [SIDE_W-1:0] diff;
    logic [19:0]       prod;
    logic [SIDE_W-1:0] q;
    span = {1'b0, side} + {7'd0, pad, 1'b0};
    k    = k3 ? 10'd3 : 10'd1;
    diff = 9'(span - k);
    prod = '0;
    q    = '0;
    case (stride)
      3'd1: q = diff;
      3'd2: q = {1'b0, diff[8:1]};
      3'd3: begin
        prod = 20'(diff) * 20'd171;
        q    = 9'(prod >> 9);
      end
      3'd4: q = {2'b00, diff[8:2]};
      3'd5: begin
        prod = 20'(diff) * 20'd205;
        q    = 9'(prod >> 10);
      end
      3'd6: begin
        prod = 20'(diff) * 20'd171;
        q    = 9'(prod >> 10);
      end
      3'd7: begin
        prod = 20'(diff) * 20'd293;
        q    = 9'(prod >> 11);
      end
      default: q = '0;
    endcase
    if (stride == 3'd0 || span < k) begin
      return '0;
    end
    return 9'(q + 9'd1);
  endfunction

endpackage

/* hdl/im2col_cfg.sv */
// Configuration registers and the values derived from them (saturated sizes, output sizes).
// Depends on im2col_pkg.
module im2col_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [im2col_pkg::IDX_W-1:0]   cfg_index,
  input  logic [im2col_pkg::CFG_W-1:0]   cfg_data,
  output im2col_pkg::cfg_t               cfg
);

  logic [8:0]  in_height_r;
  logic [8:0]  in_width_r;
  logic [10:0] in_channels_r;
  logic        kernel_is_3x3_r;
  logic [2:0]  stride_rows_r;
  logic [2:0]  stride_cols_r;
  logic [1:0]  pad_rows_r;
  logic [1:0]  pad_cols_r;

  im2col_pkg::cfg_t cfg_r;
  im2col_pkg::cfg_t cfg_nxt;
  logic [17:0]      npix_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_height_r     <= 9'd1;
      in_width_r      <= 9'd1;
      in_channels_r   <= 11'd1;
      kernel_is_3x3_r <= 1'b0;
      stride_rows_r   <= 3'd1;
      stride_cols_r   <= 3'd1;
      pad_rows_r      <= 2'd0;
      pad_cols_r      <= 2'd0;
    end else if (cfg_valid) begin
      case (im2col_pkg::reg_idx_t'(cfg_index))
        im2col_pkg::REG_IN_HEIGHT:     in_height_r     <= cfg_data[8:0];
        im2col_pkg::REG_IN_WIDTH:      in_width_r      <= cfg_data[8:0];
        im2col_pkg::REG_IN_CHANNELS:   in_channels_r   <= cfg_data[10:0];
        im2col_pkg::REG_KERNEL_IS_3X3: kernel_is_3x3_r <= cfg_data[0];
        im2col_pkg::REG_STRIDE_ROWS:   stride_rows_r   <= cfg_data[2:0];
        im2col_pkg::REG_STRIDE_COLS:   stride_cols_r   <= cfg_data[2:0];
        im2col_pkg::REG_PAD_ROWS:      pad_rows_r      <= cfg_data[1:0];
        im2col_pkg::REG_PAD_COLS:      pad_cols_r      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_nxt    = cfg_r;
    cfg_nxt.h  = (in_height_r > 9'(im2col_pkg::MAX_SIDE)) ? 9'(im2col_pkg::MAX_SIDE)
                                                          : in_height_r;
    cfg_nxt.w  = (in_width_r > 9'(im2col_pkg::MAX_SIDE)) ? 9'(im2col_pkg::MAX_SIDE)
                                                         : in_width_r;
    cfg_nxt.c  = (in_channels_r > 11'(im2col_pkg::MAX_CHANNELS))
                 ? 11'(im2col_pkg::MAX_CHANNELS) : in_channels_r;
    cfg_nxt.k3 = kernel_is_3x3_r;
    cfg_nxt.sr = stride_rows_r;
    cfg_nxt.sc = stride_cols_r;
    cfg_nxt.pr = pad_rows_r;
    cfg_nxt.pc = pad_cols_r;
    cfg_nxt.oh = im2col_pkg::out_size(cfg_nxt.h, pad_rows_r, kernel_is_3x3_r, stride_rows_r);
    cfg_nxt.ow = im2col_pkg::out_size(cfg_nxt.w, pad_cols_r, kernel_is_3x3_r, stride_cols_r);
    cfg_nxt.kk = kernel_is_3x3_r ? (14'({cfg_nxt.c, 3'b000}) + 14'(cfg_nxt.c))
                                 : 14'(cfg_nxt.c);
    cfg_nxt.c3 = 12'({cfg_nxt.c, 1'b0}) + 12'(cfg_nxt.c);
    cfg_nxt.c6 = 13'({cfg_nxt.c, 2'b00}) + 13'({cfg_nxt.c, 1'b0});
    // The pixel count is formed from the registered output sizes, so it follows them in the next cycle.
    npix_full    = cfg_r.oh * cfg_r.ow;
    cfg_nxt.npix = npix_full[16:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.h    <= 9'd1;
      cfg_r.w    <= 9'd1;
      cfg_r.c    <= 11'd1;
      cfg_r.k3   <= 1'b0;
      cfg_r.sr   <= 3'd1;
      cfg_r.sc   <= 3'd1;
      cfg_r.pr   <= 2'd0;
      cfg_r.pc   <= 2'd0;
      cfg_r.oh   <= 9'd1;
      cfg_r.ow   <= 9'd1;
      cfg_r.npix <= 17'd1;
      cfg_r.kk   <= 14'd1;
      cfg_r.c3   <= 12'd3;
      cfg_r.c6   <= 13'd6;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hdl/im2col_split.sv */
// Pipeline that splits the pixel index into output row and column with a restoring
// divider, one quotient bit per stage, and splits the K index into kernel row, column
// and channel. Depends on im2col_pkg.
module im2col_split (
  input  logic                           clk,
  input  logic                           rst_n,
  input  im2col_pkg::cfg_t               cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [im2col_pkg::PIX_W-1:0]   in_pix,
  input  logic [im2col_pkg::COL_W-1:0]   in_col,
  output logic                           out_valid,
  input  logic                           out_ready,
  output im2col_pkg::split_t             out_item
);

  localparam int LAST = im2col_pkg::SPLIT_STAGES - 1;

  im2col_pkg::split_t                       st_r   [im2col_pkg::SPLIT_STAGES];
  im2col_pkg::split_t                       st_nxt [im2col_pkg::SPLIT_STAGES];
  logic [im2col_pkg::SPLIT_STAGES-1:0]      v_r;
  logic [im2col_pkg::SPLIT_STAGES-1:0]      v_nxt;
  logic [im2col_pkg::SPLIT_STAGES-1:0]      rdy;

  function automatic im2col_pkg::split_t div_step(im2col_pkg::split_t s, int unsigned idx,
                                                  im2col_pkg::cfg_t cf);
    im2col_pkg::split_t o;
    logic [4:0]         b;
    logic [9:0]         t;
    logic [11:0]        c2;
    o  = s;
    b  = 5'(im2col_pkg::PIX_W - idx);
    t  = {s.rem, s.pix[b]};
    c2 = {cf.c, 1'b0};
    if (t >= {1'b0, cf.ow}) begin
      o.rem    = 9'(t - {1'b0, cf.ow});
      o.quo[b] = 1'b1;
    end else begin
      o.rem = t[8:0];
    end
    if (idx == 1) begin
      o.zcol = (s.col >= cf.kk);
      o.krow = 2'd0;
      if (cf.k3) begin
        if (s.col >= 14'(cf.c6)) begin
          o.krow = 2'd2;
          o.col  = s.col - 14'(cf.c6);
        end else if (s.col >= 14'(cf.c3)) begin
          o.krow = 2'd1;
          o.col  = s.col - 14'(cf.c3);
        end
      end
    end
    if (idx == 2) begin
      o.kcol = 2'd0;
      if (cf.k3) begin
        if (s.col >= 14'(c2)) begin
          o.kcol = 2'd2;
          o.col  = s.col - 14'(c2);
        end else if (s.col >= 14'(cf.c)) begin
          o.kcol = 2'd1;
          o.col  = s.col - 14'(cf.c);
        end
      end
    end
    if (idx == 3) begin
      o.zero = s.zcol || (s.pix >= cf.npix);
    end
    return o;
  endfunction

  always_comb begin
    rdy[LAST] = !v_r[LAST] || out_ready;
    for (int i = LAST - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  always_comb begin
    st_nxt[0]     = '0;
    st_nxt[0].pix = in_pix;
    st_nxt[0].col = in_col;
    v_nxt[0]      = in_valid;
    for (int i = 1; i <= LAST; i++) begin
      st_nxt[i] = div_step(st_r[i-1], i, cfg);
      v_nxt[i]  = v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i <= LAST; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i <= LAST; i++) begin
      if (rdy[i]) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[LAST];
  assign out_item  = st_r[LAST];

endmodule

/* hdl/im2col_addr.sv */
// Pipeline that forms the tap position, classifies padding and builds the NHWC address.
// Its last stage is the output register. Depends on im2col_pkg.
module im2col_addr (
  input  logic                 clk,
  input  logic                 rst_n,
  input  im2col_pkg::cfg_t     cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  im2col_pkg::split_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output im2col_pkg::addr_t    out_item
);

  localparam int LAST = im2col_pkg::ADDR_STAGES - 1;

  im2col_pkg::addr_t                    st_r   [im2col_pkg::ADDR_STAGES];
  im2col_pkg::addr_t                    st_nxt [im2col_pkg::ADDR_STAGES];
  logic [im2col_pkg::ADDR_STAGES-1:0]   v_r;
  logic [im2col_pkg::ADDR_STAGES-1:0]   v_nxt;
  logic [im2col_pkg::ADDR_STAGES-1:0]   rdy;

  always_comb begin
    rdy[LAST] = !v_r[LAST] || out_ready;
    for (int i = LAST - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  always_comb begin
    logic [11:0] ihs;
    logic [11:0] iws;
    logic        pad;
    logic [27:0] prod;

    // Tap position, still offset by the padding.
    st_nxt[0]      = '0;
    st_nxt[0].kind = im2col_pkg::KIND_ZERO;
    st_nxt[0].zero = in_item.zero;
    st_nxt[0].ihp  = 12'(in_item.quo[8:0] * cfg.sr) + 12'(in_item.krow);
    st_nxt[0].iwp  = 12'(in_item.rem * cfg.sc) + 12'(in_item.kcol);
    st_nxt[0].ch   = in_item.col[9:0];
    v_nxt[0]       = in_valid;

    // Padding check and removal of the pad offset.
    st_nxt[1] = st_r[0];
    ihs = st_r[0].ihp - 12'(cfg.pr);
    iws = st_r[0].iwp - 12'(cfg.pc);
    pad = (st_r[0].ihp < 12'(cfg.pr)) || (st_r[0].iwp < 12'(cfg.pc)) ||
          (ihs >= 12'(cfg.h)) || (iws >= 12'(cfg.w));
    st_nxt[1].ihp = ihs;
    st_nxt[1].iwp = iws;
    if (st_r[0].zero) begin
      st_nxt[1].kind = im2col_pkg::KIND_ZERO;
    end else if (pad) begin
      st_nxt[1].kind = im2col_pkg::KIND_PAD;
    end else begin
      st_nxt[1].kind = im2col_pkg::KIND_FETCH;
    end
    v_nxt[1] = v_r[0];

    // Pixel offset within the feature map.
    st_nxt[2]      = st_r[1];
    st_nxt[2].base = 17'(st_r[1].ihp[7:0] * cfg.w) + 17'(st_r[1].iwp[7:0]);
    v_nxt[2]       = v_r[1];

    // Scale by the channel count.
    st_nxt[3]      = st_r[2];
    prod           = st_r[2].base * cfg.c;
    st_nxt[3].addr = prod[im2col_pkg::ADDR_W-1:0];
    v_nxt[3]       = v_r[2];

    // Add the channel and clear the address for anything but a fetch.
    st_nxt[4] = st_r[3];
    if (st_r[3].kind == im2col_pkg::KIND_FETCH) begin
      st_nxt[4].addr = st_r[3].addr + 26'(st_r[3].ch);
    end else begin
      st_nxt[4].addr = '0;
    end
    v_nxt[4] = v_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i <= LAST; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i <= LAST; i++) begin
      if (rdy[i]) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[LAST];
  assign out_item  = st_r[LAST];

endmodule

/* hdl/im2col_gather_address_generator.sv */
// Top level of the im2col gather address generator for NHWC int8 convolution.
// Depends on im2col_pkg, im2col_cfg, im2col_split and im2col_addr.
//
// Each input transaction carries one im2col coordinate (output pixel index, column index
// in K padded to a multiple of 8). Each one yields exactly one output transaction with
// the fetch kind on out_tuser (fetch, zero-point padding, write zero) and the flat NHWC
// byte address on out_tdata, which is zero unless the kind is fetch.
// The pipeline accepts one transaction per clock while the output is not stalled and
// holds 23 stages: an input register, 17 divider stages that take one quotient bit each
// of pixel index / output width, and 5 stages that form the tap, classify padding and
// build the address. When the output is not stalled, an accepted transaction moves
// through the stages in order, and out_tvalid rises once it reaches the output register.
// Registers are written through the cfg port, always ready; a write takes effect for
// transactions accepted on the following cycle, since the derived sizes settle before
// a new transaction reaches the stages that read them.
// Reset (rst_n low, synchronous) empties the pipeline and restores the register
// defaults: 1x1 input with one channel, 1x1 kernel, stride 1, no padding.
// When the receiver holds out_tready low, the stages fill up behind the output
// register; in_tready drops only once every stage holds a transaction.
module im2col_gather_address_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [16:0] pixel_index, [30:17] col_index, [31] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [25:0] source_address, [31:26] zero
  output logic [1:0]  out_tuser,  // [1:0] fetch_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  im2col_pkg::cfg_t   cfg;
  im2col_pkg::split_t split_item;
  im2col_pkg::addr_t  addr_item;
  logic               split_valid;
  logic               split_ready;

  im2col_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  im2col_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_pix    (in_tdata[16:0]),
    .in_col    (in_tdata[30:17]),
    .out_valid (split_valid),
    .out_ready (split_ready),
    .out_item  (split_item)
  );

  im2col_addr u_addr (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (split_valid),
    .in_ready  (split_ready),
    .in_item   (split_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (addr_item)
  );

  assign out_tdata = {6'd0, addr_item.addr};
  assign out_tuser = addr_item.kind;

endmodule
